### src/cap_pkg.sv
// ----------------------------------------------------------------------------
// cap_pkg
// shared constants, widths and the arctangent table of the circle point core
// ----------------------------------------------------------------------------
package cap_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int NSTEP        = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

  localparam int DIST_W  = 32;
  localparam int LEN_W   = 31;
  localparam int PHASE_W = 32;
  localparam int DIV_STG = 32;
  localparam int XW      = 34;
  localparam int RAD_W   = 23;
  localparam int PT_W    = 24;
  localparam int TAN_W   = 16;
  localparam int PW      = XW + RAD_W + 1;
  localparam int ADDR_W  = 2;
  localparam int DATA_W  = 32;

  localparam logic signed [XW-1:0] START_X = XW'(652032874);

  localparam logic [ADDR_W-1:0] REG_CENTER_X = 2'd0;
  localparam logic [ADDR_W-1:0] REG_CENTER_Y = 2'd1;
  localparam logic [ADDR_W-1:0] REG_RADIUS   = 2'd2;
  localparam logic [ADDR_W-1:0] REG_PATH_LEN = 2'd3;

  // atan(2^-i), 2^32 units per turn
  function automatic logic [31:0] atan_f(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

### src/cap_if.sv
// ----------------------------------------------------------------------------
// cap channel interfaces
// input item, result item and register write channels
// ----------------------------------------------------------------------------
interface cap_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [cap_pkg::DIST_W-1:0]     travel_distance;
  modport source (output valid, travel_distance, input ready);
  modport sink (input valid, travel_distance, output ready);
endinterface

interface cap_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [cap_pkg::PT_W-1:0]       point_x;
  logic signed [cap_pkg::PT_W-1:0]       point_y;
  logic signed [cap_pkg::TAN_W-1:0]      tangent_x;
  logic signed [cap_pkg::TAN_W-1:0]      tangent_y;
  modport source (output valid, point_x, point_y, tangent_x, tangent_y, input ready);
  modport sink (input valid, point_x, point_y, tangent_x, tangent_y, output ready);
endinterface

interface cap_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [cap_pkg::ADDR_W-1:0]            addr;
  logic [cap_pkg::DATA_W-1:0]            wdata;
  modport source (output valid, addr, wdata, input ready);
  modport sink (input valid, addr, wdata, output ready);
endinterface

### src/cap_div.sv
// ----------------------------------------------------------------------------
// cap_div
// pipelined remainder of the distance by the path length, then the
// fractional quotient rem * 2^32 / len as the phase, one bit per stage
// ----------------------------------------------------------------------------
module cap_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                vld_i,
  input  logic signed [cap_pkg::DIST_W-1:0]   dist_i,
  input  logic [cap_pkg::LEN_W-1:0]           len_i,
  output logic                                vld_o,
  output logic [cap_pkg::PHASE_W-1:0]         phase_o
);
  import cap_pkg::*;

  logic [LEN_W-1:0]   rm_q [DIV_STG];
  logic [DIST_W-1:0]  ra_q [DIV_STG];
  logic               rs_q [DIV_STG];
  logic               rv_q [DIV_STG];
  logic [LEN_W-1:0]   fx_q;
  logic               fv_q;
  logic [LEN_W-1:0]   pr_q [DIV_STG];
  logic [PHASE_W-1:0] pq_q [DIV_STG];
  logic               pv_q [DIV_STG];
  logic [DIST_W-1:0]  abs_d;
  logic [LEN_W-1:0]   fx_d;

  assign abs_d = dist_i[DIST_W-1] ? DIST_W'(-dist_i) : DIST_W'(dist_i);

  // restoring division of |d|, one dividend bit per stage
  for (genvar i = 0; i < DIV_STG; i++) begin : g_rem
    logic [LEN_W-1:0]  r_in;
    logic [DIST_W-1:0] a_in;
    logic              s_in;
    logic              v_in;
    logic [LEN_W:0]    t;
    logic              ge;
    if (i == 0) begin : g_first
      assign r_in = '0;
      assign a_in = abs_d;
      assign s_in = dist_i[DIST_W-1];
      assign v_in = vld_i;
    end else begin : g_next
      assign r_in = rm_q[i-1];
      assign a_in = ra_q[i-1];
      assign s_in = rs_q[i-1];
      assign v_in = rv_q[i-1];
    end
    assign t  = {r_in, a_in[DIST_W-1]};
    assign ge = t >= {1'b0, len_i};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rm_q[i] <= ge ? LEN_W'(t - {1'b0, len_i}) : t[LEN_W-1:0];
        ra_q[i] <= {a_in[DIST_W-2:0], 1'b0};
        rs_q[i] <= s_in;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rv_q[i] <= 1'b0;
      end else if (en_i) begin
        rv_q[i] <= v_in;
      end
    end
  end

  // negative distance with nonzero remainder wraps up by one length
  assign fx_d = (rs_q[DIV_STG-1] && (rm_q[DIV_STG-1] != '0)) ?
                LEN_W'(len_i - rm_q[DIV_STG-1]) : rm_q[DIV_STG-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fx_q <= fx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (en_i) begin
      fv_q <= rv_q[DIV_STG-1];
    end
  end

  for (genvar i = 0; i < DIV_STG; i++) begin : g_phase
    logic [LEN_W-1:0]   r_in;
    logic [PHASE_W-1:0] q_in;
    logic               v_in;
    logic [LEN_W:0]     t;
    logic               ge;
    if (i == 0) begin : g_first
      assign r_in = fx_q;
      assign q_in = '0;
      assign v_in = fv_q;
    end else begin : g_next
      assign r_in = pr_q[i-1];
      assign q_in = pq_q[i-1];
      assign v_in = pv_q[i-1];
    end
    assign t  = {r_in, 1'b0};
    assign ge = t >= {1'b0, len_i};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pr_q[i] <= ge ? LEN_W'(t - {1'b0, len_i}) : t[LEN_W-1:0];
        pq_q[i] <= {q_in[PHASE_W-2:0], ge};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pv_q[i] <= 1'b0;
      end else if (en_i) begin
        pv_q[i] <= v_in;
      end
    end
  end

  assign vld_o   = pv_q[DIV_STG-1];
  assign phase_o = pq_q[DIV_STG-1];

  a_rem_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q[DIV_STG-1] |-> (rm_q[DIV_STG-1] < len_i))
    else $error("remainder not below path length");

  a_fix_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fv_q |-> (fx_q < len_i))
    else $error("wrapped distance not below path length");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(pv_q[DIV_STG-1]) && $stable(phase_o))
    else $error("phase stage moved during stall");

endmodule

### src/cap_cordic.sv
// ----------------------------------------------------------------------------
// cap_cordic
// rotation mode cordic, one micro-rotation per pipeline stage
// ----------------------------------------------------------------------------
module cap_cordic (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               vld_i,
  input  logic [cap_pkg::PHASE_W-1:0]        phase_i,
  output logic                               vld_o,
  output logic [1:0]                         quad_o,
  output logic signed [cap_pkg::XW-1:0]      x_o,
  output logic signed [cap_pkg::XW-1:0]      y_o
);
  import cap_pkg::*;

  logic signed [XW-1:0] x_q [NSTEP];
  logic signed [XW-1:0] y_q [NSTEP];
  logic signed [XW-1:0] z_q [NSTEP];
  logic [1:0]           qd_q [NSTEP];
  logic                 v_q [NSTEP];

  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    logic signed [XW-1:0] x_in;
    logic signed [XW-1:0] y_in;
    logic signed [XW-1:0] z_in;
    logic [1:0]           qd_in;
    logic                 v_in;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [XW-1:0] at;
    if (i == 0) begin : g_first
      assign x_in  = START_X;
      assign y_in  = '0;
      assign z_in  = $signed({{(XW-PHASE_W+2){1'b0}}, phase_i[PHASE_W-3:0]});
      assign qd_in = phase_i[PHASE_W-1:PHASE_W-2];
      assign v_in  = vld_i;
    end else begin : g_next
      assign x_in  = x_q[i-1];
      assign y_in  = y_q[i-1];
      assign z_in  = z_q[i-1];
      assign qd_in = qd_q[i-1];
      assign v_in  = v_q[i-1];
    end
    assign dx = y_in >>> i;
    assign dy = x_in >>> i;
    assign at = $signed({{(XW-32){1'b0}}, atan_f(i)});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_in[XW-1]) begin
          x_q[i] <= x_in - dx;
          y_q[i] <= y_in + dy;
          z_q[i] <= z_in - at;
        end else begin
          x_q[i] <= x_in + dx;
          y_q[i] <= y_in - dy;
          z_q[i] <= z_in + at;
        end
        qd_q[i] <= qd_in;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end
  end

  assign vld_o  = v_q[NSTEP-1];
  assign quad_o = qd_q[NSTEP-1];
  assign x_o    = x_q[NSTEP-1];
  assign y_o    = y_q[NSTEP-1];

endmodule

### src/cap_post.sv
// ----------------------------------------------------------------------------
// cap_post
// quadrant fold, radius scaling, rounding and saturation of the result item
// ----------------------------------------------------------------------------
module cap_post (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               vld_i,
  input  logic [1:0]                         quad_i,
  input  logic signed [cap_pkg::XW-1:0]      x_i,
  input  logic signed [cap_pkg::XW-1:0]      y_i,
  input  logic signed [cap_pkg::PT_W-1:0]    cx_i,
  input  logic signed [cap_pkg::PT_W-1:0]    cy_i,
  input  logic [cap_pkg::RAD_W-1:0]          rad_i,
  output logic                               vld_o,
  output logic signed [cap_pkg::PT_W-1:0]    px_o,
  output logic signed [cap_pkg::PT_W-1:0]    py_o,
  output logic signed [cap_pkg::TAN_W-1:0]   tx_o,
  output logic signed [cap_pkg::TAN_W-1:0]   ty_o
);
  import cap_pkg::*;

  localparam logic signed [PW-1:0] P_MAX = PW'(8388607);
  localparam logic signed [PW-1:0] P_MIN = -PW'(8388608);
  localparam logic signed [XW-1:0] T_MAX = XW'(32767);
  localparam logic signed [XW-1:0] T_MIN = -XW'(32768);

  logic signed [XW-1:0] c;
  logic signed [XW-1:0] s;
  logic signed [PW-1:0] mx_q, my_q;
  logic signed [XW-1:0] rc_q, rs_q;
  logic                 av_q;
  logic signed [PW-1:0] sx, sy;
  logic signed [XW-1:0] ntx;
  logic                 bv_q;
  logic signed [PT_W-1:0]  px_q, py_q;
  logic signed [TAN_W-1:0] tx_q, ty_q;
  logic signed [PW-1:0] rad_w;

  always_comb begin
    case (quad_i)
      2'd0: begin c = x_i;  s = y_i;  end
      2'd1: begin c = -y_i; s = x_i;  end
      2'd2: begin c = -x_i; s = -y_i; end
      default: begin c = y_i; s = -x_i; end
    endcase
  end

  assign rad_w = $signed({{(PW-RAD_W){1'b0}}, rad_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx_q <= rad_w * PW'(c);
      my_q <= rad_w * PW'(s);
      rc_q <= (c + XW'(16384)) >>> 15;
      rs_q <= (s + XW'(16384)) >>> 15;
    end
  end

  // round half up from q2.30, then add the center
  assign sx  = ((mx_q + PW'(536870912)) >>> 30) + PW'(cx_i);
  assign sy  = ((my_q + PW'(536870912)) >>> 30) + PW'(cy_i);
  assign ntx = -rs_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q <= (sx > P_MAX) ? PT_W'(P_MAX) : (sx < P_MIN) ? PT_W'(P_MIN) : PT_W'(sx);
      py_q <= (sy > P_MAX) ? PT_W'(P_MAX) : (sy < P_MIN) ? PT_W'(P_MIN) : PT_W'(sy);
      tx_q <= (ntx > T_MAX) ? TAN_W'(T_MAX) : (ntx < T_MIN) ? TAN_W'(T_MIN) : TAN_W'(ntx);
      ty_q <= (rc_q > T_MAX) ? TAN_W'(T_MAX) : (rc_q < T_MIN) ? TAN_W'(T_MIN) : TAN_W'(rc_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      av_q <= 1'b0;
      bv_q <= 1'b0;
    end else if (en_i) begin
      av_q <= vld_i;
      bv_q <= av_q;
    end
  end

  assign vld_o = bv_q;
  assign px_o  = px_q;
  assign py_o  = py_q;
  assign tx_o  = tx_q;
  assign ty_o  = ty_q;

endmodule

### src/circle_arc_point_and_tangent_core.sv
// ----------------------------------------------------------------------------
// circle_arc_point_and_tangent_core
// point on a circle and unit tangent at a wrapped travel distance
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  din_i    in   travel_distance
//  dout_o   out  point_x, point_y, tangent_x, tangent_y
//  cfg_i    in   addr, wdata (center_x, center_y, circle_radius, path_length)
//
//  one item per cycle while the output is not stalled; the pipeline holds 32
//  remainder stages, one wrap stage, 32 phase stages, one cordic stage per
//  step and two output stages.
//  the whole pipeline advances when the output register is empty or taken;
//  a stall freezes every stage with its valid bit.
//  reset clears valid bits and loads register defaults; cfg is always ready.
// ----------------------------------------------------------------------------
module circle_arc_point_and_tangent_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  cap_in_if.sink     din_i,
  cap_out_if.source  dout_o,
  cap_cfg_if.sink    cfg_i
);
  import cap_pkg::*;

  logic signed [PT_W-1:0] cx_q, cy_q;
  logic [RAD_W-1:0]       rad_q;
  logic [LEN_W-1:0]       len_q;
  logic [LEN_W-1:0]       len_eff;
  logic                   en;
  logic                   out_vld;
  logic                   dv;
  logic [PHASE_W-1:0]     phase;
  logic                   cv;
  logic [1:0]             quad;
  logic signed [XW-1:0]   cx, cy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cy_q  <= '0;
      rad_q <= RAD_W'(256);
      len_q <= LEN_W'(1608);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.addr)
        REG_CENTER_X: cx_q  <= cfg_i.wdata[PT_W-1:0];
        REG_CENTER_Y: cy_q  <= cfg_i.wdata[PT_W-1:0];
        REG_RADIUS:   rad_q <= cfg_i.wdata[RAD_W-1:0];
        REG_PATH_LEN: len_q <= cfg_i.wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;
  // zero length behaves as one
  assign len_eff     = (len_q == '0) ? LEN_W'(1) : len_q;
  assign en          = !out_vld || dout_o.ready;
  assign din_i.ready = en;

  cap_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (din_i.valid),
    .dist_i  (din_i.travel_distance),
    .len_i   (len_eff),
    .vld_o   (dv),
    .phase_o (phase)
  );

  cap_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (dv),
    .phase_i (phase),
    .vld_o   (cv),
    .quad_o  (quad),
    .x_o     (cx),
    .y_o     (cy)
  );

  cap_post u_post (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (cv),
    .quad_i (quad),
    .x_i    (cx),
    .y_i    (cy),
    .cx_i   (cx_q),
    .cy_i   (cy_q),
    .rad_i  (rad_q),
    .vld_o  (out_vld),
    .px_o   (dout_o.point_x),
    .py_o   (dout_o.point_y),
    .tx_o   (dout_o.tangent_x),
    .ty_o   (dout_o.tangent_y)
  );

  assign dout_o.valid = out_vld;

endmodule

### test/circle_arc_point_and_tangent_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circle_arc_point_and_tangent_core_tb
// drives travel distances under several center, radius and path length
// settings, predicts point and tangent with a cordic model and checks every
// result item in order, with random gaps on the input and stalls on the output
// ----------------------------------------------------------------------------
module circle_arc_point_and_tangent_core_tb;
  import cap_pkg::*;

  localparam int LATENCY = 67 + NSTEP;

  typedef struct packed {
    logic signed [PT_W-1:0]  px;
    logic signed [PT_W-1:0]  py;
    logic signed [TAN_W-1:0] tx;
    logic signed [TAN_W-1:0] ty;
  } point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cap_in_if  din ();
  cap_out_if dout ();
  cap_cfg_if cfg ();

  circle_arc_point_and_tangent_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .din_i  (din),
    .dout_o (dout),
    .cfg_i  (cfg)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mirrored register state
  logic signed [23:0] ctr_x = '0;
  logic signed [23:0] ctr_y = '0;
  logic [22:0]        radius = 23'd256;
  logic [30:0]        perimeter = 31'd1608;

  point_t points_due[$];
  int     mismatches = 0;
  int     results_seen = 0;
  int     settings_run = 0;
  bit     stall_hard = 0;

  function automatic longint shr_arith(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic point_t circle_point(logic signed [31:0] trav_d);
    longint len, rem, x, y, z, dx, dy, c, s, rad;
    logic [63:0] phase;
    logic [1:0] quad;
    point_t r;
    len = perimeter;
    if (len == 0) len = 1;
    rem = longint'(trav_d) % len;
    if (rem < 0) rem += len;
    phase = (64'(rem) << 32) / 64'(len);
    quad = phase[31:30];
    z = longint'(phase[29:0]);
    x = 652032874;
    y = 0;
    for (int i = 0; i < NSTEP; i++) begin
      dx = shr_arith(y, i);
      dy = shr_arith(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_f(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_f(i));
      end
    end
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    rad = radius;
    r.px = PT_W'(sat(longint'(ctr_x) + shr_arith(rad * c + 536870912, 30),
                     -8388608, 8388607));
    r.py = PT_W'(sat(longint'(ctr_y) + shr_arith(rad * s + 536870912, 30),
                     -8388608, 8388607));
    r.tx = TAN_W'(sat(-shr_arith(s + 16384, 15), -32768, 32767));
    r.ty = TAN_W'(sat(shr_arith(c + 16384, 15), -32768, 32767));
    return r;
  endfunction

  initial begin
    din.valid = 1'b0;
    din.travel_distance = '0;
    cfg.valid = 1'b0;
    cfg.addr = REG_CENTER_X;
    cfg.wdata = '0;
    dout.ready = 1'b0;
  end

  // receiver stalls: alternates open stretches with random stall patterns
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      dout.ready <= 1'b0;
    end else if (stall_hard) begin
      dout.ready <= ($urandom_range(0, 3) == 0);
    end else begin
      dout.ready <= ($urandom_range(0, 7) != 0);
    end
  end

  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_hard <= !stall_hard;
  end

  always @(posedge clk_i) begin
    point_t got, want;
    if (rst_ni && dout.valid && dout.ready) begin
      got = '{dout.point_x, dout.point_y, dout.tangent_x, dout.tangent_y};
      results_seen++;
      if (points_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %p", got);
      end else begin
        want = points_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected px %0d py %0d tx %0d ty %0d,",
                      " got px %0d py %0d tx %0d ty %0d"},
                     want.px, want.py, want.tx, want.ty,
                     got.px, got.py, got.tx, got.ty);
        end
      end
    end
  end

  task automatic send_distance(logic signed [31:0] trav_d);
    din.valid <= 1'b1;
    din.travel_distance <= trav_d;
    @(posedge clk_i);
    while (!din.ready) @(posedge clk_i);
    points_due.push_back(circle_point(trav_d));
    @(negedge clk_i);
  endtask

  task automatic pause_sender();
    din.valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [ADDR_W-1:0] idx, logic [31:0] data);
    cfg.valid <= 1'b1;
    cfg.addr <= idx;
    cfg.wdata <= data;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    case (idx)
      REG_CENTER_X: ctr_x = data[23:0];
      REG_CENTER_Y: ctr_y = data[23:0];
      REG_RADIUS:   radius = data[22:0];
      default:      perimeter = data[30:0];
    endcase
    @(negedge clk_i);
  endtask

  task automatic drain();
    din.valid <= 1'b0;
    while (points_due.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic set_circle(logic [31:0] cx, logic [31:0] cy, logic [31:0] r,
                            logic [31:0] len);
    drain();
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_RADIUS, r);
    write_reg(REG_PATH_LEN, len);
    cfg.valid <= 1'b0;
    settings_run++;
  endtask

  // extremes of the distance, quadrant edges and wrap points
  task automatic test_directed();
    logic signed [31:0] corners[$];
    logic signed [31:0] len;
    len = perimeter;
    corners = '{32'sh7fffffff, 32'sh80000000, 0, -1, 1, len, -len, len - 1,
                len / 4, len / 2, 3 * len / 4, -(len / 4), 2 * len + 7,
                32'sh55555555, 32'shaaaaaaaa};
    foreach (corners[k]) send_distance(corners[k]);
    din.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic test_random(int n);
    int burst;
    logic signed [31:0] d;
    while (n > 0) begin
      burst = $urandom_range(1, 20);
      if ($urandom_range(0, 3) == 0) burst = 0;
      for (int k = 0; k < burst && n > 0; k++, n--) begin
        case ($urandom_range(0, 3))
          0: d = $urandom;
          1: d = $signed($urandom_range(0, 4000)) - 2000;
          2: d = $signed(32'($urandom_range(0, 2 * perimeter))) -
                 $signed(32'(perimeter));
          default: d = $signed(32'($urandom)) >>> $urandom_range(0, 31);
        endcase
        send_distance(d);
      end
      if ($urandom_range(0, 2) != 0) pause_sender();
    end
    din.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic test_settings();
    set_circle(32'h7fffff, 32'h800000, 32'h7fffff, 32'h7fffffff);
    test_directed();
    test_random(100);
    set_circle(32'h800000, 32'h7fffff, 32'h0, 32'h1);
    test_directed();
    test_random(60);
    set_circle(32'h123456, 32'hfedcba, 32'h400000, 32'h0);
    test_random(40);
    set_circle(32'h000100, 32'hffff00, 32'h002000, 32'h80000000);
    test_directed();
    test_random(60);
    for (int k = 0; k < 4; k++) begin
      set_circle($urandom, $urandom, $urandom, $urandom_range(1, 32'h7fffffff));
      test_random(60);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(150);
    test_settings();
    drain();
    $display("covered %0d result items over %0d register settings plus defaults",
             results_seen, settings_run);
    if (mismatches == 0 && points_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d items missing", mismatches, points_due.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout");
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### files.f
src/cap_pkg.sv
src/cap_if.sv
src/cap_div.sv
src/cap_cordic.sv
src/cap_post.sv
src/circle_arc_point_and_tangent_core.sv
test/circle_arc_point_and_tangent_core_tb.sv
